/* hdl/kms_pkg.sv */
// Shared types and constants of the key matrix change scanner.
`timescale 1ns / 1ps

package kms_pkg;

  localparam int ROW_W     = 8;
  localparam int COL_W     = 3;
  localparam int KEY_W     = 6;
  localparam int CNT_W     = 4;
  localparam int CFG_IDX_W = 1;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = 1;
  localparam int QCNT_W    = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 1'b1;

  localparam logic [CNT_W-1:0] CNT_RESET = 4'd8;

  typedef struct packed {
    logic [ROW_W-1:0] chg;
    logic [ROW_W-1:0] prs;
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] next;
  } job_t;

endpackage

/* hdl/key_matrix_change_scanner.sv */
// Keypad matrix scanner with per-key change events.
// Path: tick into the queue, then the request register, then the output registers.
// Throughput: one tick taken per cycle while the two-entry queue has room; the
// emitter gives one result per cycle unless stalled, max(1, changed keys) per tick.
// Reset: all keys released, column zero, both row and column counts eight,
// queue and output empty.
`timescale 1ns / 1ps

module key_matrix_change_scanner import kms_pkg::*; #(
  parameter int ROWS = 8,
  parameter int COLS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [ROW_W-1:0]     in_row_levels,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [COL_W-1:0]     out_drive_column,
  output logic                 out_event_valid,
  output logic [KEY_W-1:0]     out_key_index,
  output logic                 out_key_pressed,
  output logic                 out_last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_data
);

  job_t fj;
  job_t qj;
  logic fj_push;
  logic q_full;
  logic q_empty;
  logic q_pop;

  assign in_full = q_full;

  kms_front #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (q_full),
    .in_row_levels (in_row_levels),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .job           (fj),
    .job_push      (fj_push)
  );

  kms_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fj_push),
    .wdata (fj),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (qj),
    .empty (q_empty)
  );

  kms_back #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_data           (qj),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_drive_column (out_drive_column),
    .out_event_valid  (out_event_valid),
    .out_key_index    (out_key_index),
    .out_key_pressed  (out_key_pressed),
    .out_last         (out_last)
  );

endmodule

/* hdl/kms_front.sv */
// Front end: register file, key state, column sequencing and change detection.
`timescale 1ns / 1ps

module kms_front import kms_pkg::*; #(
  parameter int ROWS = 8,
  parameter int COLS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  logic                 in_full,
  input  logic [ROW_W-1:0]     in_row_levels,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_data,
  output job_t                 job,
  output logic                 job_push
);

  localparam int CIDX_W = (COLS > 1) ? $clog2(COLS) : 1;

  logic [CNT_W-1:0] rows_r;
  logic [CNT_W-1:0] cols_r;
  logic [COL_W-1:0] col_r;
  logic [ROWS-1:0]  ks_r [COLS];

  logic [CNT_W-1:0] nrows;
  logic [CNT_W-1:0] ncols;
  logic [COL_W-1:0] scan_col;
  logic [CNT_W-1:0] col_inc;
  logic [COL_W-1:0] next_col;
  logic [ROWS-1:0]  cur;
  logic [ROWS-1:0]  rmask;
  logic [ROWS-1:0]  now;
  logic [ROWS-1:0]  chg;

  always_comb begin
    nrows = (rows_r > CNT_W'(ROWS)) ? CNT_W'(ROWS) : rows_r;
    priority if (cols_r == '0) begin
      ncols = CNT_W'(1);
    end else if (cols_r > CNT_W'(COLS)) begin
      ncols = CNT_W'(COLS);
    end else begin
      ncols = cols_r;
    end
    scan_col = ({1'b0, col_r} >= ncols) ? '0 : col_r;
    col_inc  = {1'b0, scan_col} + CNT_W'(1);
    next_col = (col_inc >= ncols) ? '0 : col_inc[COL_W-1:0];
    cur      = ks_r[scan_col[CIDX_W-1:0]];
    for (int r = 0; r < ROWS; r++) begin
      rmask[r] = (CNT_W'(r) < nrows);
    end
    now = ~in_row_levels[ROWS-1:0];
    chg = rmask & (now ^ cur);
  end

  assign job_push = in_push & ~in_full;

  always_comb begin
    job.chg  = ROW_W'(chg);
    job.prs  = ROW_W'(now);
    job.col  = scan_col;
    job.next = next_col;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= CNT_RESET;
      cols_r <= CNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROWS_IN_USE: rows_r <= cfg_data;
        CFG_COLS_IN_USE: cols_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      for (int c = 0; c < COLS; c++) begin
        ks_r[c] <= '0;
      end
    end else if (job_push) begin
      col_r <= next_col;
      ks_r[scan_col[CIDX_W-1:0]] <= cur ^ chg;
    end
  end

endmodule

/* hdl/kms_queue.sv */
// Short request queue between the front end and the event emitter.
`timescale 1ns / 1ps

module kms_queue import kms_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t wdata,
  output logic full,
  input  logic pop,
  output job_t rdata,
  output logic empty
);

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

endmodule

/* hdl/kms_back.sv */
// Back end: walks each request's change mask and emits one event per cycle while the output is not stalled.
`timescale 1ns / 1ps

module kms_back import kms_pkg::*; #(
  parameter int ROWS = 8,
  parameter int COLS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  job_t             q_data,
  input  logic             q_empty,
  output logic             q_pop,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [COL_W-1:0] out_drive_column,
  output logic             out_event_valid,
  output logic [KEY_W-1:0] out_key_index,
  output logic             out_key_pressed,
  output logic             out_last
);

  job_t             job_r;
  logic             job_v_r;
  logic             out_v_r;
  logic [COL_W-1:0] col_r;
  logic             ev_r;
  logic [KEY_W-1:0] key_r;
  logic             prs_r;
  logic             last_r;

  logic             adv;
  logic             step;
  logic             fin;
  logic [2:0]       sel;
  logic [ROW_W-1:0] rem;
  logic             ev;
  logic [KEY_W-1:0] key;

  always_comb begin
    sel = '0;
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (job_r.chg[i]) begin
        sel = 3'(i);
      end
    end
    adv   = ~out_v_r | out_pop;
    step  = job_v_r & adv;
    rem   = job_r.chg & ~(ROW_W'(1) << sel);
    fin   = step & (rem == '0);
    q_pop = ~q_empty & (~job_v_r | fin);
    ev    = |job_r.chg;
    key   = ev ? (KEY_W'(sel * COLS) + KEY_W'(job_r.col)) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (q_pop) begin
        job_v_r <= 1'b1;
      end else if (fin) begin
        job_v_r <= 1'b0;
      end
      if (adv) begin
        out_v_r <= job_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_data;
    end else if (step) begin
      job_r.chg <= rem;
    end
    if (step) begin
      col_r  <= job_r.next;
      ev_r   <= ev;
      key_r  <= key;
      prs_r  <= ev & job_r.prs[sel];
      last_r <= (rem == '0);
    end
  end

  assign out_empty        = ~out_v_r;
  assign out_drive_column = col_r;
  assign out_event_valid  = ev_r;
  assign out_key_index    = key_r;
  assign out_key_pressed  = prs_r;
  assign out_last         = last_r;

endmodule
